// ===== rtl/qskv_pkg.sv =====
// Shared types and constants for the query string key/value parser.
// No dependencies; every other file of the block refers to this package.
package qskv_pkg;

  localparam int WS_DEPTH = 16;
  localparam int WS_IDX_W = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
  localparam int WS_CNT_W = $clog2(WS_DEPTH + 1);
  localparam int SEQ_W    = $clog2(WS_DEPTH + 4);
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    CFG_PAIR_SEP  = 2'd0,
    CFG_KEY_SEP   = 2'd1,
    CFG_UNESC_EN  = 2'd2,
    CFG_TRIM_EN   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_KEY_CHAR   = 3'd0,
    KIND_VALUE_CHAR = 3'd1,
    KIND_KEY_END    = 3'd2,
    KIND_VALUE_END  = 3'd3,
    KIND_ERROR      = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } out_item_t;

  typedef struct packed {
    logic                ws_wr;
    logic                ws_tab;
    logic [WS_IDX_W-1:0] ws_idx;
    logic [WS_CNT_W-1:0] flush_cnt;
    logic                char_en;
    logic                char_val;
    logic [7:0]          char_byte;
    logic [1:0]          mark_cnt;
    kind_t               mark0;
    kind_t               mark1;
    logic                done;
  } cmd_t;

endpackage

// ===== rtl/qskv_front.sv =====
// Front end: configuration registers, per-byte parse state and command build.
// Depends on qskv_pkg.
module qskv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_push,
  input  qskv_pkg::in_item_t  in_data,
  input  logic                q_full,
  output logic                q_push,
  output qskv_pkg::cmd_t      q_cmd
);

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;
  localparam logic [7:0] CH_PCT   = 8'h25;

  logic [7:0] pair_sep_r;
  logic [7:0] key_sep_r;
  logic       unesc_en_r;
  logic       trim_en_r;

  logic                          value_mode_r, value_mode_nxt;
  logic                          at_start_r, at_start_nxt;
  logic [1:0]                    esc_r, esc_nxt;
  logic [3:0]                    hi_nib_r, hi_nib_nxt;
  logic [qskv_pkg::WS_CNT_W-1:0] ws_cnt_r, ws_cnt_nxt;
  logic                          err_r, err_nxt;

  logic           accept;
  logic [7:0]     b;
  logic           last;
  logic [4:0]     hexd;
  logic           do_fc;
  logic           fc_val;
  logic [7:0]     fc_byte;
  logic           vend_if_last;
  logic           fc_fail;
  logic           fc_ws;
  logic           fail_any;
  qskv_pkg::cmd_t cmd;

  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  assign accept = in_push && !q_full;
  assign b      = in_data.in_byte;
  assign last   = in_data.in_last;
  assign hexd   = hex_dec(b);
  assign fc_ws  = (fc_byte == qskv_pkg::CH_SPACE) || (fc_byte == qskv_pkg::CH_TAB);

  always_comb begin
    cmd            = '0;
    cmd.mark0      = qskv_pkg::KIND_ERROR;
    cmd.mark1      = qskv_pkg::KIND_ERROR;
    value_mode_nxt = value_mode_r;
    at_start_nxt   = at_start_r;
    esc_nxt        = esc_r;
    hi_nib_nxt     = hi_nib_r;
    ws_cnt_nxt     = ws_cnt_r;
    err_nxt        = err_r;
    do_fc          = 1'b0;
    fc_val         = 1'b0;
    fc_byte        = b;
    vend_if_last   = 1'b0;
    fc_fail        = 1'b0;
    fail_any       = 1'b0;

    priority if (err_r) begin
    end else if (!value_mode_r) begin
      if (b == key_sep_r) begin
        cmd.mark0      = qskv_pkg::KIND_KEY_END;
        value_mode_nxt = 1'b1;
        at_start_nxt   = 1'b1;
        ws_cnt_nxt     = '0;
        if (last) begin
          cmd.mark1    = qskv_pkg::KIND_VALUE_END;
          cmd.mark_cnt = 2'd2;
        end else begin
          cmd.mark_cnt = 2'd1;
        end
      end else if (last) begin
        fail_any = 1'b1;
      end else begin
        do_fc = 1'b1;
      end
    end else if (b == pair_sep_r) begin
      if (esc_r != ESC_NONE) begin
        fail_any = 1'b1;
      end else begin
        cmd.mark0 = qskv_pkg::KIND_VALUE_END;
        if (last) begin
          cmd.mark_cnt = 2'd2;
          err_nxt      = 1'b1;
        end else begin
          cmd.mark_cnt   = 2'd1;
          value_mode_nxt = 1'b0;
          at_start_nxt   = 1'b1;
          ws_cnt_nxt     = '0;
        end
      end
    end else if (esc_r == ESC_HIGH) begin
      if (!hexd[4]) begin
        fail_any = 1'b1;
      end else begin
        hi_nib_nxt = hexd[3:0];
        esc_nxt    = ESC_LOW;
        if (last) fail_any = 1'b1;
      end
    end else if (esc_r == ESC_LOW) begin
      if (!hexd[4]) begin
        fail_any = 1'b1;
      end else begin
        esc_nxt      = ESC_NONE;
        do_fc        = 1'b1;
        fc_val       = 1'b1;
        fc_byte      = {hi_nib_r, hexd[3:0]};
        vend_if_last = 1'b1;
      end
    end else if (b == CH_PCT && unesc_en_r) begin
      esc_nxt = ESC_HIGH;
      if (last) fail_any = 1'b1;
    end else begin
      do_fc        = 1'b1;
      fc_val       = 1'b1;
      vend_if_last = 1'b1;
    end

    if (do_fc) begin
      if (trim_en_r && fc_ws) begin
        if (!at_start_r) begin
          if (ws_cnt_r >= qskv_pkg::WS_CNT_W'(qskv_pkg::WS_DEPTH)) begin
            fc_fail = 1'b1;
          end else begin
            cmd.ws_wr  = !last;
            cmd.ws_tab = (fc_byte == qskv_pkg::CH_TAB);
            cmd.ws_idx = ws_cnt_r[qskv_pkg::WS_IDX_W-1:0];
            ws_cnt_nxt = ws_cnt_r + 1'b1;
          end
        end
      end else begin
        cmd.flush_cnt = ws_cnt_r;
        cmd.char_en   = 1'b1;
        cmd.char_val  = fc_val;
        cmd.char_byte = fc_byte;
        ws_cnt_nxt    = '0;
        at_start_nxt  = 1'b0;
      end
    end

    if (fail_any || fc_fail) begin
      cmd.mark0    = qskv_pkg::KIND_ERROR;
      cmd.mark_cnt = 2'd1;
      err_nxt      = 1'b1;
    end else if (vend_if_last && last) begin
      cmd.mark0    = qskv_pkg::KIND_VALUE_END;
      cmd.mark_cnt = 2'd1;
    end

    cmd.done = err_nxt || last;

    if (last) begin
      value_mode_nxt = 1'b0;
      esc_nxt        = ESC_NONE;
      hi_nib_nxt     = '0;
      err_nxt        = 1'b0;
      at_start_nxt   = 1'b1;
      ws_cnt_nxt     = '0;
    end
  end

  assign q_cmd  = cmd;
  assign q_push = accept && !err_r && (cmd.ws_wr || cmd.char_en || (cmd.mark_cnt != 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_sep_r <= 8'd38;
      key_sep_r  <= 8'd61;
      unesc_en_r <= 1'b1;
      trim_en_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (qskv_pkg::cfg_idx_t'(cfg_idx))
        qskv_pkg::CFG_PAIR_SEP: pair_sep_r <= cfg_wdata;
        qskv_pkg::CFG_KEY_SEP:  key_sep_r  <= cfg_wdata;
        qskv_pkg::CFG_UNESC_EN: unesc_en_r <= cfg_wdata[0];
        qskv_pkg::CFG_TRIM_EN:  trim_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_mode_r <= 1'b0;
      at_start_r   <= 1'b1;
      esc_r        <= ESC_NONE;
      hi_nib_r     <= '0;
      ws_cnt_r     <= '0;
      err_r        <= 1'b0;
    end else if (accept) begin
      value_mode_r <= value_mode_nxt;
      at_start_r   <= at_start_nxt;
      esc_r        <= esc_nxt;
      hi_nib_r     <= hi_nib_nxt;
      ws_cnt_r     <= ws_cnt_nxt;
      err_r        <= err_nxt;
    end
  end

  a_no_cmd_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && err_r) |-> !q_push)
    else $error("command issued while dropping the rest of a string");

  a_ws_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ws_cnt_r <= qskv_pkg::WS_CNT_W'(qskv_pkg::WS_DEPTH))
    else $error("held whitespace count beyond buffer depth");

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (!err_r && !value_mode_r && esc_r == ESC_NONE && ws_cnt_r == '0))
    else $error("parser not re-armed after final byte");

endmodule

// ===== rtl/qskv_cmd_q.sv =====
// Short command queue between front end and result sequencer.
// Depends on qskv_pkg.
module qskv_cmd_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  qskv_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output qskv_pkg::cmd_t dout,
  output logic           empty
);

  qskv_pkg::cmd_t                mem_r [qskv_pkg::CQ_DEPTH];
  logic [qskv_pkg::CQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [qskv_pkg::CQ_CNT_W-1:0] cnt_r;
  logic                          do_wr, do_rd;

  assign full  = (cnt_r == qskv_pkg::CQ_CNT_W'(qskv_pkg::CQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == qskv_pkg::CQ_PTR_W'(qskv_pkg::CQ_DEPTH - 1)) ? '0
                    : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == qskv_pkg::CQ_PTR_W'(qskv_pkg::CQ_DEPTH - 1)) ? '0
                    : rd_ptr_r + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/qskv_back.sv =====
// Result sequencer: held-whitespace buffer, per-command result walk, output register.
// Depends on qskv_pkg.
module qskv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  qskv_pkg::cmd_t      q_cmd,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output qskv_pkg::out_item_t out_data
);

  logic                          ws_kind_r [qskv_pkg::WS_DEPTH];
  logic [qskv_pkg::SEQ_W-1:0]    pos_r, pos_nxt;
  logic                          out_valid_r, out_valid_nxt;
  qskv_pkg::out_item_t           out_data_r, res;

  logic                       head_valid;
  logic                       ws_we;
  logic                       pop_ok;
  logic                       load;
  logic                       last_one;
  logic [qskv_pkg::SEQ_W-1:0] total;
  logic [qskv_pkg::SEQ_W-1:0] flush_end;
  qskv_pkg::kind_t            char_kind;

  assign head_valid = !q_empty;
  assign ws_we      = head_valid && q_cmd.ws_wr;
  assign pop_ok     = out_pop && out_valid_r;
  assign load       = head_valid && !q_cmd.ws_wr && (!out_valid_r || pop_ok);
  assign flush_end  = qskv_pkg::SEQ_W'(q_cmd.flush_cnt);
  assign total      = flush_end + qskv_pkg::SEQ_W'(q_cmd.char_en)
                      + qskv_pkg::SEQ_W'(q_cmd.mark_cnt);
  assign last_one   = (pos_r == total - 1'b1);
  assign char_kind  = q_cmd.char_val ? qskv_pkg::KIND_VALUE_CHAR : qskv_pkg::KIND_KEY_CHAR;

  always_comb begin
    res          = '0;
    res.kind     = qskv_pkg::KIND_ERROR;
    priority if (pos_r < flush_end) begin
      res.kind     = char_kind;
      res.out_byte = ws_kind_r[pos_r[qskv_pkg::WS_IDX_W-1:0]] ? qskv_pkg::CH_TAB
                     : qskv_pkg::CH_SPACE;
    end else if (pos_r == flush_end && q_cmd.char_en) begin
      res.kind     = char_kind;
      res.out_byte = q_cmd.char_byte;
    end else if (pos_r == flush_end + qskv_pkg::SEQ_W'(q_cmd.char_en)) begin
      res.kind = q_cmd.mark0;
    end else begin
      res.kind = q_cmd.mark1;
    end
    res.run_last    = last_one;
    res.string_done = last_one && q_cmd.done;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (load) pos_nxt = last_one ? '0 : pos_r + 1'b1;
  end

  assign out_valid_nxt = load ? 1'b1 : (pop_ok ? 1'b0 : out_valid_r);
  assign q_pop         = ws_we || (load && last_one);
  assign out_empty     = !out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (ws_we) ws_kind_r[q_cmd.ws_idx] <= q_cmd.ws_tab;
    if (load)  out_data_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_cmd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && !q_cmd.ws_wr) |-> (total != '0))
    else $error("queued command carries no results");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && !q_cmd.ws_wr) |-> (pos_r < total))
    else $error("result position past end of command");

endmodule

// ===== rtl/query_string_key_value_parser.sv =====
// Top level of the query string key/value parser.
// Depends on qskv_pkg, qskv_front, qskv_cmd_q and qskv_back.
//
// Bytes of a query string go in one per cycle while in_full is low; a four-entry
// command queue separates the byte classifier from the result sequencer, which
// emits one result per cycle into a single output register unless the output
// stalls. A byte that causes k results holds the sequencer until all k are out
// (k is at most 18, reached when the final character of a string releases
// sixteen held whitespace characters and closes the value), a held whitespace
// byte yields no result and bytes dropped after an error are not queued, so the
// sustained byte rate is one per cycle except across multi-result bursts and
// output stalls. Each byte's command is registered in the queue and its results
// in the output register. No clearing pass follows reset; bytes go in at once.
module query_string_key_value_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_push,
  output logic                in_full,
  input  qskv_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output qskv_pkg::out_item_t out_data
);

  logic           q_push, q_full, q_pop, q_empty;
  qskv_pkg::cmd_t q_din, q_dout;

  assign in_full = q_full;

  qskv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_din)
  );

  qskv_cmd_q u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  qskv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (q_dout),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
